// ----- src/ugq_pkg.sv -----
// Shared types and constants for the undirected graph query engine.
package ugq_pkg;

	// Fixed field widths of the request, result and register beats.
	localparam int REQ_W = 3;
	localparam int VTX_W = 4;
	localparam int CNT_W = 9;
	localparam int VC_W  = 5;

	// Vertex count after reset.
	localparam logic [VC_W-1:0] VERTEX_COUNT_RESET = 5'd16;

	// Saturation value of the degree sum.
	localparam logic [CNT_W-1:0] COUNT_MAX = 9'd511;

	// Request codes.
	typedef enum logic [REQ_W-1:0] {
		REQ_CLEAR      = 3'd0,
		REQ_ADD_EDGE   = 3'd1,
		REQ_DEGREE     = 3'd2,
		REQ_DEGREE_SUM = 3'd3,
		REQ_DFS_ORDER  = 3'd4,
		REQ_CONNECTED  = 3'd5,
		REQ_PATH       = 3'd6,
		REQ_NONE       = 3'd7
	} req_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE_A,
		ST_EDGE_B,
		ST_DEGREE,
		ST_SUM,
		ST_SCAN,
		ST_POP,
		ST_REPORT
	} state_t;

	// Control of the adjacency store.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} adj_ctl_t;

endpackage

// ----- src/ugq_adj_mem.sv -----
// Adjacency row store with one write and one registered read port, and row valid bits.
module ugq_adj_mem #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ugq_pkg::adj_ctl_t                  ctl,
	input  logic [$clog2(MAX_VERTICES)-1:0]    rd_addr,
	input  logic [$clog2(MAX_VERTICES)-1:0]    wr_addr,
	input  logic [MAX_VERTICES-1:0]            wr_data,
	output logic [MAX_VERTICES-1:0]            rd_data
);
	import ugq_pkg::*;

	logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] row_valid_q;
	logic [MAX_VERTICES-1:0] rd_data_q;

	// Row storage; a row that has not been written since the last clear reads as zero.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= row_valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	// Row valid bits: cleared at reset and by a clear request, set by a write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (ctl.clear) begin
			row_valid_q <= '0;
		end else if (ctl.wr_en) begin
			row_valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/ugq_stack_mem.sv -----
// Walk stack store: one write port and one registered read port.
module ugq_stack_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 9
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Entries are only read after they have been pushed.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/ugq_row_unit.sv -----
// Shared row unit: population count of a masked row and search for the first candidate column.
module ugq_row_unit #(
	parameter int MAX_VERTICES = 16
) (
	input  logic [MAX_VERTICES-1:0]             row,
	input  logic [MAX_VERTICES-1:0]             count_mask,
	input  logic [MAX_VERTICES-1:0]             scan_mask,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]   start,
	output logic                                found,
	output logic [$clog2(MAX_VERTICES)-1:0]     first,
	output logic [$clog2(MAX_VERTICES+1)-1:0]   pop
);
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES+1);

	logic [MAX_VERTICES-1:0] cand;

	// Candidates are masked columns at or above the start column.
	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			cand[i] = row[i] & scan_mask[i] & (CW'(i) >= start);
		end
	end

	// Lowest candidate column wins.
	always_comb begin
		first = '0;
		for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
			if (cand[i]) begin
				first = VW'(i);
			end
		end
	end

	assign found = |cand;
	assign pop   = CW'($countones(row & count_mask));

endmodule

// ----- src/undirected_graph_query_engine.sv -----
// Top level of the undirected graph query engine: request sequencer and result register.
//
// Holds a symmetric adjacency bit matrix for up to MAX_VERTICES vertices and serves one request
// at a time; in_stall is high from the beat after acceptance until the request's last result has
// been loaded into the output register, which may still wait for the consumer while the next
// request is taken. With C the effective vertex count, a clear goes straight to the report state,
// an edge insert reads and rewrites both end rows, a degree query reads and counts one row and a
// degree sum reads all C rows. A depth-first request (visit order, connectivity or path) reads one
// adjacency row per step from the row store's read port and runs it through the one shared row
// unit, and a backtrack needs an extra read of the walk stack. Output stalls lengthen a request.
// Rows are cleared at once through per-row valid bits, so no clearing pass follows reset.
module undirected_graph_query_engine #(
	parameter int MAX_VERTICES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [ugq_pkg::VC_W-1:0]   cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ugq_pkg::REQ_W-1:0]  req_type,
	input  logic [ugq_pkg::VTX_W-1:0]  vertex_a,
	input  logic [ugq_pkg::VTX_W-1:0]  vertex_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [ugq_pkg::VTX_W-1:0]  visited_vertex,
	output logic [ugq_pkg::CNT_W-1:0]  count_value,
	output logic                       answer_flag,
	output logic                       error_flag,
	output logic                       last_of_run
);
	import ugq_pkg::*;

	localparam int VW   = $clog2(MAX_VERTICES);
	localparam int CW   = $clog2(MAX_VERTICES+1);
	localparam int KW   = (CW > VC_W) ? CW : VC_W;
	localparam int SEW  = VW + CW;
	localparam int SUMW = CNT_W + 1;
	localparam logic [MAX_VERTICES-1:0] ONE_BIT = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	// Control registers.
	state_t                  state_q, state_d;
	logic [VC_W-1:0]         vc_q;
	logic [MAX_VERTICES-1:0] visited_q;
	logic [VW-1:0]           sp_q;
	logic                    pending_q;
	logic                    out_valid_q;

	// Working registers.
	req_t                    mode_q;
	logic [VW-1:0]           a_q;
	logic [VW-1:0]           b_q;
	logic [VW-1:0]           top_v_q;
	logic [CW-1:0]           top_next_q;
	logic [CW-1:0]           idx_q;
	logic [CNT_W-1:0]        acc_q;
	logic [VW-1:0]           rep_vertex_q;
	logic [CNT_W-1:0]        rep_count_q;
	logic                    rep_answer_q;
	logic                    rep_error_q;

	// Output register.
	logic [VTX_W-1:0]        out_vertex_q;
	logic [CNT_W-1:0]        out_count_q;
	logic                    out_answer_q;
	logic                    out_error_q;
	logic                    out_last_q;

	// Decoded request and effective vertex count.
	req_t                    req;
	logic [KW-1:0]           eff_ext;
	logic [CW-1:0]           eff_cnt;
	logic [KW-1:0]           a_ext;
	logic [KW-1:0]           b_ext;
	logic                    a_ok;
	logic                    b_ok;
	logic [VW-1:0]           a_idx;
	logic [VW-1:0]           b_idx;
	logic [MAX_VERTICES-1:0] colmask;
	logic                    in_acc;

	// Shared unit and store connections.
	logic [MAX_VERTICES-1:0] ru_scan_mask;
	logic [CW-1:0]           ru_start;
	logic                    ru_found;
	logic [VW-1:0]           ru_first;
	logic [CW-1:0]           ru_pop;
	adj_ctl_t                adj_ctl;
	logic [VW-1:0]           adj_rd_addr;
	logic [VW-1:0]           adj_wr_addr;
	logic [MAX_VERTICES-1:0] adj_wr_data;
	logic [MAX_VERTICES-1:0] adj_rd_data;
	logic                    stk_wr_en;
	logic                    stk_rd_en;
	logic [VW-1:0]           stk_rd_addr;
	logic [SEW-1:0]          stk_wr_data;
	logic [SEW-1:0]          stk_rd_data;

	// Sequencer strobes.
	logic                    out_free;
	logic                    out_load;
	logic                    out_last;
	logic                    push;
	logic                    scan_done;
	logic                    sum_issue;
	logic                    sum_done;
	logic [SUMW-1:0]         sum_ext;
	logic [CNT_W-1:0]        sum_sat;

	// Effective count, range checks and column mask.
	always_comb begin
		logic [KW-1:0] vc_ext;
		logic [KW-1:0] max_ext;
		vc_ext  = KW'(vc_q);
		max_ext = KW'(MAX_VERTICES);
		if (vc_ext == '0) begin
			eff_ext = KW'(1);
		end else if (vc_ext > max_ext) begin
			eff_ext = max_ext;
		end else begin
			eff_ext = vc_ext;
		end
		for (int i = 0; i < MAX_VERTICES; i++) begin
			colmask[i] = KW'(i) < eff_ext;
		end
	end

	assign eff_cnt = eff_ext[CW-1:0];
	assign a_ext   = KW'(vertex_a);
	assign b_ext   = KW'(vertex_b);
	assign a_ok    = a_ext < eff_ext;
	assign b_ok    = b_ext < eff_ext;
	assign a_idx   = a_ext[VW-1:0];
	assign b_idx   = b_ext[VW-1:0];
	assign req     = req_t'(req_type);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The shared row unit serves degree counts and the walk's neighbour search.
	assign ru_scan_mask = colmask & ~visited_q;
	assign ru_start     = (state_q == ST_SCAN) ? top_next_q : '0;

	ugq_row_unit #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_row_unit (
		.row       (adj_rd_data),
		.count_mask(colmask),
		.scan_mask (ru_scan_mask),
		.start     (ru_start),
		.found     (ru_found),
		.first     (ru_first),
		.pop       (ru_pop)
	);

	ugq_adj_mem #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_adj_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (adj_ctl),
		.rd_addr(adj_rd_addr),
		.wr_addr(adj_wr_addr),
		.wr_data(adj_wr_data),
		.rd_data(adj_rd_data)
	);

	ugq_stack_mem #(
		.DEPTH(MAX_VERTICES),
		.WIDTH(SEW)
	) u_stack_mem (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr(sp_q),
		.wr_data(stk_wr_data),
		.rd_en  (stk_rd_en),
		.rd_addr(stk_rd_addr),
		.rd_data(stk_rd_data)
	);

	// Saturating degree sum.
	assign sum_ext = {1'b0, acc_q} + SUMW'(ru_pop);
	assign sum_sat = (sum_ext > SUMW'(COUNT_MAX)) ? COUNT_MAX : sum_ext[CNT_W-1:0];

	assign sum_issue = (state_q == ST_SUM) && (idx_q < eff_cnt);
	assign sum_done  = (state_q == ST_SUM) && !(idx_q < eff_cnt) && !pending_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (req)
						REQ_CLEAR:      state_d = ST_REPORT;
						REQ_ADD_EDGE:   state_d = (a_ok && b_ok) ? ST_EDGE_A : ST_REPORT;
						REQ_DEGREE:     state_d = a_ok ? ST_DEGREE : ST_REPORT;
						REQ_DEGREE_SUM: state_d = ST_SUM;
						REQ_DFS_ORDER:  state_d = ST_SCAN;
						REQ_CONNECTED:  state_d = ST_SCAN;
						REQ_PATH: begin
							state_d = (a_ok && b_ok && (a_idx != b_idx)) ? ST_SCAN : ST_REPORT;
						end
						REQ_NONE:       state_d = ST_IDLE;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_EDGE_A: state_d = ST_EDGE_B;
			ST_EDGE_B: state_d = ST_REPORT;
			ST_DEGREE: state_d = ST_REPORT;
			ST_SUM:    state_d = sum_done ? ST_REPORT : ST_SUM;
			ST_SCAN: begin
				if (ru_found) begin
					state_d = ST_SCAN;
				end else if (sp_q == '0) begin
					state_d = ST_REPORT;
				end else begin
					state_d = ST_POP;
				end
			end
			ST_POP:    state_d = ST_SCAN;
			ST_REPORT: state_d = out_free ? ST_IDLE : ST_REPORT;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: store accesses, stack moves and result loads.
	always_comb begin
		adj_ctl     = '0;
		adj_rd_addr = '0;
		adj_wr_addr = '0;
		adj_wr_data = '0;
		stk_wr_en   = 1'b0;
		stk_rd_en   = 1'b0;
		stk_rd_addr = sp_q - VW'(1);
		stk_wr_data = {top_v_q, CW'(ru_first) + CW'(1)};
		out_load    = 1'b0;
		out_last    = 1'b0;
		push        = 1'b0;
		scan_done   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (req)
						REQ_CLEAR: begin
							adj_ctl.clear = 1'b1;
						end
						REQ_ADD_EDGE, REQ_DEGREE: begin
							adj_ctl.rd_en = 1'b1;
							adj_rd_addr   = a_idx;
						end
						REQ_DFS_ORDER, REQ_CONNECTED: begin
							adj_ctl.rd_en = 1'b1;
							adj_rd_addr   = '0;
						end
						REQ_PATH: begin
							adj_ctl.rd_en = 1'b1;
							adj_rd_addr   = a_idx;
						end
						REQ_DEGREE_SUM, REQ_NONE: begin
							adj_ctl = '0;
						end
						default: begin
							adj_ctl = '0;
						end
					endcase
				end
			end
			ST_EDGE_A: begin
				adj_ctl.wr_en = 1'b1;
				adj_wr_addr   = a_q;
				adj_wr_data   = adj_rd_data | (ONE_BIT << b_q);
				adj_ctl.rd_en = 1'b1;
				adj_rd_addr   = b_q;
			end
			ST_EDGE_B: begin
				adj_ctl.wr_en = 1'b1;
				adj_wr_addr   = b_q;
				adj_wr_data   = adj_rd_data | (ONE_BIT << a_q);
			end
			ST_DEGREE: begin
				adj_ctl = '0;
			end
			ST_SUM: begin
				adj_ctl.rd_en = sum_issue;
				adj_rd_addr   = idx_q[VW-1:0];
			end
			ST_SCAN: begin
				if (ru_found) begin
					// A visit-order walk hands the previous vertex on before it moves.
					if ((mode_q != REQ_DFS_ORDER) || out_free) begin
						push          = 1'b1;
						stk_wr_en     = 1'b1;
						adj_ctl.rd_en = 1'b1;
						adj_rd_addr   = ru_first;
						out_load      = (mode_q == REQ_DFS_ORDER);
					end
				end else if (sp_q == '0) begin
					scan_done = 1'b1;
				end else begin
					stk_rd_en = 1'b1;
				end
			end
			ST_POP: begin
				adj_ctl.rd_en = 1'b1;
				adj_rd_addr   = stk_rd_data[SEW-1:CW];
			end
			ST_REPORT: begin
				out_load = out_free;
				out_last = 1'b1;
			end
			default: begin
				adj_ctl = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vc_q        <= VERTEX_COUNT_RESET;
			visited_q   <= '0;
			sp_q        <= '0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				vc_q <= cfg_wr_data;
			end
			if (in_acc) begin
				visited_q <= ONE_BIT << ((req == REQ_PATH) ? a_idx : '0);
				sp_q      <= '0;
				pending_q <= 1'b0;
			end else if (push) begin
				visited_q <= visited_q | (ONE_BIT << ru_first);
				sp_q      <= sp_q + VW'(1);
			end else if (state_q == ST_POP) begin
				sp_q <= sp_q - VW'(1);
			end else if (state_q == ST_SUM) begin
				pending_q <= sum_issue;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the current request.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q       <= req;
			a_q          <= a_idx;
			b_q          <= b_idx;
			top_v_q      <= (req == REQ_PATH) ? a_idx : '0;
			top_next_q   <= '0;
			idx_q        <= '0;
			acc_q        <= '0;
			rep_vertex_q <= '0;
			rep_count_q  <= '0;
			rep_answer_q <= (req == REQ_PATH) && a_ok && b_ok && (a_idx == b_idx);
			unique case (req)
				REQ_ADD_EDGE, REQ_PATH: rep_error_q <= !(a_ok && b_ok);
				REQ_DEGREE:             rep_error_q <= !a_ok;
				REQ_CLEAR, REQ_DEGREE_SUM, REQ_DFS_ORDER, REQ_CONNECTED, REQ_NONE: begin
					rep_error_q <= 1'b0;
				end
				default:                rep_error_q <= 1'b0;
			endcase
		end
		if (state_q == ST_DEGREE) begin
			rep_count_q <= CNT_W'(ru_pop);
		end
		if ((state_q == ST_SUM) && pending_q) begin
			acc_q <= sum_sat;
		end
		if (sum_issue) begin
			idx_q <= idx_q + CW'(1);
		end
		if (sum_done) begin
			rep_count_q <= acc_q;
		end
		if (push) begin
			top_v_q    <= ru_first;
			top_next_q <= '0;
			if (mode_q == REQ_DFS_ORDER) begin
				rep_vertex_q <= ru_first;
			end
		end
		if (state_q == ST_POP) begin
			top_v_q    <= stk_rd_data[SEW-1:CW];
			top_next_q <= stk_rd_data[CW-1:0];
		end
		if (scan_done) begin
			if (mode_q == REQ_CONNECTED) begin
				rep_answer_q <= ((visited_q & colmask) == colmask);
			end else if (mode_q == REQ_PATH) begin
				rep_answer_q <= visited_q[b_q];
			end else begin
				rep_answer_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_vertex_q <= VTX_W'(rep_vertex_q);
			out_count_q  <= rep_count_q;
			out_answer_q <= rep_answer_q;
			out_error_q  <= rep_error_q;
			out_last_q   <= out_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign visited_vertex = out_vertex_q;
	assign count_value    = out_count_q;
	assign answer_flag    = out_answer_q;
	assign error_flag     = out_error_q;
	assign last_of_run    = out_last_q;

	// The walk stack is empty whenever no request is in progress.
	a_idle_stack_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (sp_q == '0))
		else $error("walk stack not empty while idle");

	// The vertex on top of the walk is always marked as visited.
	a_top_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> visited_q[top_v_q])
		else $error("top of walk not marked visited");

	// A backtrack step always returns to scanning.
	a_pop_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |=> (state_q == ST_SCAN))
		else $error("backtrack did not return to scanning");

	// A result is never loaded over one that the consumer is still stalling.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("result register overwritten while stalled");

	// New requests are taken only once the previous one has produced its last beat.
	a_accept_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && out_last) |=> (state_q == ST_IDLE))
		else $error("sequencer not idle after last result");

endmodule
